>>> design/iesc_pkg.sv
// Shared types and constants for the infix expression syntax checker.
package iesc_pkg;

  localparam int unsigned MaxNest    = 255;
  localparam int unsigned NestW      = $clog2(MaxNest + 1);
  localparam int unsigned FifoDepth  = 4;  // power of two
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);

  localparam logic [7:0] ChLBrace = 8'h7B;
  localparam logic [7:0] ChRBrace = 8'h7D;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic OpChar = 1'b0;
  localparam logic OpEnd  = 1'b1;

  typedef enum logic [2:0] {
    ClsDigit,
    ClsLBrace,
    ClsRBrace,
    ClsLParen,
    ClsRParen,
    ClsOper,
    ClsSpace,
    ClsIllegal
  } char_cls_e;

  typedef struct packed {
    logic      is_end;
    char_cls_e cls;
  } item_t;

  typedef enum logic [1:0] {
    VerdictOpen  = 2'd0,
    VerdictValid = 2'd1,
    VerdictError = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ErrNone       = 4'd0,
    ErrEmpty      = 4'd1,
    ErrOpenBrace  = 4'd2,
    ErrAdjacent   = 4'd3,
    ErrBadLParen  = 4'd4,
    ErrExtraRParen = 4'd5,
    ErrRParenOp   = 4'd6,
    ErrMisplacedOp = 4'd7,
    ErrSpace      = 4'd8,
    ErrIllegal    = 4'd9,
    ErrOpenParen  = 4'd10,
    ErrTrailingOp = 4'd11,
    ErrTooDeep    = 4'd12
  } err_e;

endpackage

>>> design/infix_expression_syntax_checker_core.sv
// Top level of the infix expression syntax checker.
// Each beat is stored in the token queue, then registered as a result in the back end.
// Throughput: one character or end marker per cycle while the output is not stalled;
// a 4-entry token queue absorbs output stalls.
// Reset: rst_ni clears parser state, the queue and the output valid at once.
// Every input beat produces exactly one output beat.
module infix_expression_syntax_checker_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_code
  input  logic       s_axis_tuser,  // [0] opcode
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [1:0] verdict, [5:2] error_code, [7:6] zero
);

  iesc_pkg::item_t    front_item;
  iesc_pkg::item_t    fifo_item;
  logic               fifo_valid;
  logic               back_pop;
  iesc_pkg::verdict_e verdict;
  iesc_pkg::err_e     error_code;

  iesc_front u_front (
    .opcode_i    (s_axis_tuser),
    .char_code_i (s_axis_tdata),
    .item_o      (front_item)
  );

  iesc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .item_i  (front_item),
    .ready_o (s_axis_tready),
    .pop_i   (back_pop),
    .valid_o (fifo_valid),
    .item_o  (fifo_item)
  );

  iesc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fifo_valid),
    .item_i       (fifo_item),
    .pop_o        (back_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .verdict_o    (verdict),
    .error_code_o (error_code)
  );

  assign m_axis_tdata = {2'b00, error_code, verdict};

endmodule

>>> design/iesc_front.sv
// Front end: classifies each incoming character into a token class.
module iesc_front (
  input  logic           opcode_i,
  input  logic [7:0]     char_code_i,
  output iesc_pkg::item_t item_o
);

  iesc_pkg::char_cls_e cls;

  always_comb begin
    if (char_code_i inside {[iesc_pkg::ChZero:iesc_pkg::ChNine]}) begin
      cls = iesc_pkg::ClsDigit;
    end else if (char_code_i == iesc_pkg::ChLBrace) begin
      cls = iesc_pkg::ClsLBrace;
    end else if (char_code_i == iesc_pkg::ChRBrace) begin
      cls = iesc_pkg::ClsRBrace;
    end else if (char_code_i == iesc_pkg::ChLParen) begin
      cls = iesc_pkg::ClsLParen;
    end else if (char_code_i == iesc_pkg::ChRParen) begin
      cls = iesc_pkg::ClsRParen;
    end else if (char_code_i inside {iesc_pkg::ChPlus, iesc_pkg::ChMinus,
                                     iesc_pkg::ChStar, iesc_pkg::ChSlash}) begin
      cls = iesc_pkg::ClsOper;
    end else if (char_code_i inside {[8'h09:8'h0D], 8'h20, 8'h85, 8'hA0}) begin
      cls = iesc_pkg::ClsSpace;
    end else begin
      cls = iesc_pkg::ClsIllegal;
    end
  end

  assign item_o.is_end = (opcode_i == iesc_pkg::OpEnd);
  assign item_o.cls    = cls;

endmodule

>>> design/iesc_fifo.sv
// Short token queue between front end and checker back end.
module iesc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  iesc_pkg::item_t item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output iesc_pkg::item_t item_o
);

  iesc_pkg::item_t                 mem_q [iesc_pkg::FifoDepth];
  logic [iesc_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [iesc_pkg::FifoCntW-1:0]   cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign ready_o = (cnt_q != iesc_pkg::FifoCntW'(iesc_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> design/iesc_back.sv
// Back end: syntax state machine, error latch and registered result beat.
module iesc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  iesc_pkg::item_t       item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output iesc_pkg::verdict_e    verdict_o,
  output iesc_pkg::err_e        error_code_o
);

  logic                     want_q, want_d;
  logic                     brace_q, brace_d;
  logic                     adj_q, adj_d;
  logic                     num_q, num_d;
  logic [iesc_pkg::NestW-1:0] depth_q, depth_d;
  logic                     seen_q, seen_d;
  iesc_pkg::err_e           err_q, err_d;
  iesc_pkg::err_e           res;
  iesc_pkg::err_e           end_code;
  logic                     out_valid_q;
  iesc_pkg::verdict_e       verdict_q, verdict_d;
  iesc_pkg::err_e           code_q, code_d;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    want_d   = want_q;
    brace_d  = brace_q;
    adj_d    = adj_q;
    num_d    = num_q;
    depth_d  = depth_q;
    res      = iesc_pkg::ErrNone;
    if (brace_q) begin
      if (item_i.cls == iesc_pkg::ClsRBrace) begin
        brace_d = 1'b0;
        if (adj_q) begin
          adj_d = 1'b0;
          res   = iesc_pkg::ErrAdjacent;
        end else begin
          want_d = 1'b0;
        end
      end
    end else if (item_i.cls == iesc_pkg::ClsDigit) begin
      if (!num_q) begin
        if (!want_q) begin
          res = iesc_pkg::ErrAdjacent;
        end else begin
          num_d  = 1'b1;
          want_d = 1'b0;
        end
      end
    end else begin
      num_d = 1'b0;
      case (item_i.cls)
        iesc_pkg::ClsLBrace: begin
          brace_d = 1'b1;
          adj_d   = !want_q;
        end
        iesc_pkg::ClsLParen: begin
          if (!want_q) begin
            res = iesc_pkg::ErrBadLParen;
          end else if (depth_q >= iesc_pkg::NestW'(iesc_pkg::MaxNest)) begin
            res = iesc_pkg::ErrTooDeep;
          end else begin
            depth_d = depth_q + 1'b1;
          end
        end
        iesc_pkg::ClsRParen: begin
          if (depth_q == '0) begin
            res = iesc_pkg::ErrExtraRParen;
          end else if (want_q) begin
            res = iesc_pkg::ErrRParenOp;
          end else begin
            depth_d = depth_q - 1'b1;
          end
        end
        iesc_pkg::ClsOper: begin
          if (want_q) begin
            res = iesc_pkg::ErrMisplacedOp;
          end else begin
            want_d = 1'b1;
          end
        end
        iesc_pkg::ClsSpace: res = iesc_pkg::ErrSpace;
        default:            res = iesc_pkg::ErrIllegal;
      endcase
    end

    if (err_q != iesc_pkg::ErrNone) begin
      end_code = err_q;
    end else if (!seen_q) begin
      end_code = iesc_pkg::ErrEmpty;
    end else if (brace_q) begin
      end_code = iesc_pkg::ErrOpenBrace;
    end else if (depth_q != '0) begin
      end_code = iesc_pkg::ErrOpenParen;
    end else if (want_q) begin
      end_code = iesc_pkg::ErrTrailingOp;
    end else begin
      end_code = iesc_pkg::ErrNone;
    end

    seen_d    = seen_q;
    err_d     = err_q;
    verdict_d = verdict_q;
    code_d    = code_q;
    if (item_i.is_end) begin
      want_d    = 1'b1;
      brace_d   = 1'b0;
      adj_d     = 1'b0;
      num_d     = 1'b0;
      depth_d   = '0;
      seen_d    = 1'b0;
      err_d     = iesc_pkg::ErrNone;
      code_d    = end_code;
      verdict_d = (end_code != iesc_pkg::ErrNone) ? iesc_pkg::VerdictError
                                                  : iesc_pkg::VerdictValid;
    end else begin
      seen_d = 1'b1;
      if (err_q != iesc_pkg::ErrNone) begin
        want_d  = want_q;
        brace_d = brace_q;
        adj_d   = adj_q;
        num_d   = num_q;
        depth_d = depth_q;
      end else begin
        err_d = res;
      end
      code_d    = err_d;
      verdict_d = (err_d != iesc_pkg::ErrNone) ? iesc_pkg::VerdictError
                                               : iesc_pkg::VerdictOpen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      want_q      <= 1'b1;
      brace_q     <= 1'b0;
      adj_q       <= 1'b0;
      num_q       <= 1'b0;
      depth_q     <= '0;
      seen_q      <= 1'b0;
      err_q       <= iesc_pkg::ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        want_q  <= want_d;
        brace_q <= brace_d;
        adj_q   <= adj_d;
        num_q   <= num_d;
        depth_q <= depth_d;
        seen_q  <= seen_d;
        err_q   <= err_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      verdict_q <= verdict_d;
      code_q    <= code_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign verdict_o    = verdict_q;
  assign error_code_o = code_q;

  a_open_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && verdict_q != iesc_pkg::VerdictError |-> code_q == iesc_pkg::ErrNone)
    else $error("non-error verdict carries an error code");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= iesc_pkg::NestW'(iesc_pkg::MaxNest))
    else $error("nesting depth beyond bound");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && item_i.is_end |=> !seen_q && depth_q == '0 && err_q == iesc_pkg::ErrNone)
    else $error("end marker did not clear state");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !item_i.is_end && err_q != iesc_pkg::ErrNone |=> err_q == $past(err_q))
    else $error("latched error changed");

endmodule

>>> tb/infix_expression_syntax_checker_core_tb.sv
// Self-checking testbench for the infix expression syntax checker core.
module infix_expression_syntax_checker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                 op;
    logic [7:0]           ch;
    logic                 typed;
    iesc_pkg::verdict_e   v;
    iesc_pkg::err_e       e;
  } stim_row_t;

  typedef struct packed {
    iesc_pkg::verdict_e v;
    iesc_pkg::err_e     e;
  } verdict_t;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] char_code
  logic       s_axis_tuser  = 1'b0;   // [0] opcode
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [1:0] verdict, [5:2] error_code, [7:6] zero

  infix_expression_syntax_checker_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  localparam int unsigned DirRows = 30;

  // directed table: expected verdicts typed in only for end markers and error codes
  localparam stim_row_t DirTable [DirRows] = '{
    '{iesc_pkg::OpEnd,  8'hFF,             1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrEmpty},
    '{iesc_pkg::OpChar, "5",               1'b0, iesc_pkg::VerdictOpen,  iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChLBrace, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChRBrace, 1'b1, iesc_pkg::VerdictError,
      iesc_pkg::ErrAdjacent},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrAdjacent},
    '{iesc_pkg::OpChar, iesc_pkg::ChLBrace, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrOpenBrace},
    '{iesc_pkg::OpChar, "1",     1'b0, iesc_pkg::VerdictOpen,  iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChLParen, 1'b1, iesc_pkg::VerdictError,
      iesc_pkg::ErrBadLParen},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrBadLParen},
    '{iesc_pkg::OpChar, iesc_pkg::ChRParen, 1'b1, iesc_pkg::VerdictError,
      iesc_pkg::ErrExtraRParen},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrExtraRParen},
    '{iesc_pkg::OpChar, iesc_pkg::ChLParen, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChRParen, 1'b1, iesc_pkg::VerdictError,
      iesc_pkg::ErrRParenOp},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrRParenOp},
    '{iesc_pkg::OpChar, iesc_pkg::ChPlus, 1'b1, iesc_pkg::VerdictError,
      iesc_pkg::ErrMisplacedOp},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrMisplacedOp},
    '{iesc_pkg::OpChar, 8'hA0,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrSpace},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrSpace},
    '{iesc_pkg::OpChar, 8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrIllegal},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrIllegal},
    '{iesc_pkg::OpChar, iesc_pkg::ChLParen, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrOpenParen},
    '{iesc_pkg::OpChar, "9",     1'b0, iesc_pkg::VerdictOpen,  iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChSlash, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictError, iesc_pkg::ErrTrailingOp},
    '{iesc_pkg::OpChar, iesc_pkg::ChLBrace, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, 8'hFF,   1'b0, iesc_pkg::VerdictOpen,  iesc_pkg::ErrNone},
    '{iesc_pkg::OpChar, iesc_pkg::ChRBrace, 1'b0, iesc_pkg::VerdictOpen, iesc_pkg::ErrNone},
    '{iesc_pkg::OpEnd,  8'h00,   1'b1, iesc_pkg::VerdictValid, iesc_pkg::ErrNone}
  };

  stim_row_t   stim_q [$];
  verdict_t    pending_q [$];
  int unsigned err_cnt      = 0;
  int unsigned results_seen = 0;
  int unsigned expr_total   = 0;
  logic [15:0] codes_seen   = '0;

  // predictor state
  logic                       expect_operand;
  logic                       in_placeholder;
  logic                       placeholder_adj;
  logic                       in_digits;
  logic [iesc_pkg::NestW-1:0] paren_depth;
  logic                       any_char;
  iesc_pkg::err_e             first_err;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $error("run did not finish in time");
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void syntax_clear();
    expect_operand  = 1'b1;
    in_placeholder  = 1'b0;
    placeholder_adj = 1'b0;
    in_digits       = 1'b0;
    paren_depth     = '0;
    any_char        = 1'b0;
    first_err       = iesc_pkg::ErrNone;
  endfunction

  function automatic iesc_pkg::err_e scan_char(logic [7:0] ch);
    if (in_placeholder) begin
      if (ch == iesc_pkg::ChRBrace) begin
        in_placeholder = 1'b0;
        if (placeholder_adj) begin
          placeholder_adj = 1'b0;
          return iesc_pkg::ErrAdjacent;
        end
        expect_operand = 1'b0;
      end
      return iesc_pkg::ErrNone;
    end
    if (ch >= iesc_pkg::ChZero && ch <= iesc_pkg::ChNine) begin
      if (in_digits) return iesc_pkg::ErrNone;
      if (!expect_operand) return iesc_pkg::ErrAdjacent;
      in_digits      = 1'b1;
      expect_operand = 1'b0;
      return iesc_pkg::ErrNone;
    end
    in_digits = 1'b0;
    case (ch)
      iesc_pkg::ChLBrace: begin
        in_placeholder  = 1'b1;
        placeholder_adj = !expect_operand;
        return iesc_pkg::ErrNone;
      end
      iesc_pkg::ChLParen: begin
        if (!expect_operand) return iesc_pkg::ErrBadLParen;
        if (paren_depth >= iesc_pkg::MaxNest) return iesc_pkg::ErrTooDeep;
        paren_depth++;
        return iesc_pkg::ErrNone;
      end
      iesc_pkg::ChRParen: begin
        if (paren_depth == 0) return iesc_pkg::ErrExtraRParen;
        if (expect_operand) return iesc_pkg::ErrRParenOp;
        paren_depth--;
        return iesc_pkg::ErrNone;
      end
      iesc_pkg::ChPlus, iesc_pkg::ChMinus, iesc_pkg::ChStar, iesc_pkg::ChSlash: begin
        if (expect_operand) return iesc_pkg::ErrMisplacedOp;
        expect_operand = 1'b1;
        return iesc_pkg::ErrNone;
      end
      default: ;
    endcase
    if ((ch >= 8'h09 && ch <= 8'h0D) || ch == 8'h20 || ch == 8'h85 || ch == 8'hA0)
      return iesc_pkg::ErrSpace;
    return iesc_pkg::ErrIllegal;
  endfunction

  function automatic void syntax_step(logic op, logic [7:0] ch,
                                      output iesc_pkg::verdict_e v,
                                      output iesc_pkg::err_e e);
    iesc_pkg::err_e code;
    if (op == iesc_pkg::OpChar) begin
      any_char = 1'b1;
      if (first_err == iesc_pkg::ErrNone) first_err = scan_char(ch);
      v = (first_err != iesc_pkg::ErrNone) ? iesc_pkg::VerdictError : iesc_pkg::VerdictOpen;
      e = first_err;
    end else begin
      code = first_err;
      if (code == iesc_pkg::ErrNone) begin
        if (!any_char) code = iesc_pkg::ErrEmpty;
        else if (in_placeholder) code = iesc_pkg::ErrOpenBrace;
        else if (paren_depth != 0) code = iesc_pkg::ErrOpenParen;
        else if (expect_operand) code = iesc_pkg::ErrTrailingOp;
      end
      v = (code != iesc_pkg::ErrNone) ? iesc_pkg::VerdictError : iesc_pkg::VerdictValid;
      e = code;
      syntax_clear();
    end
  endfunction

  function automatic void push_char(logic [7:0] c);
    stim_q.push_back(stim_row_t'{iesc_pkg::OpChar, c, 1'b0, iesc_pkg::VerdictOpen,
                                 iesc_pkg::ErrNone});
  endfunction

  function automatic void push_end();
    stim_q.push_back(stim_row_t'{iesc_pkg::OpEnd, 8'($urandom_range(0, 255)), 1'b0,
                                 iesc_pkg::VerdictOpen, iesc_pkg::ErrNone});
    expr_total++;
  endfunction

  // nesting at the bound: one past it, a misplaced '(' there, or a full valid climb
  function automatic void add_deep(int unsigned kind);
    repeat (iesc_pkg::MaxNest) push_char(iesc_pkg::ChLParen);
    case (kind)
      0: push_char(iesc_pkg::ChLParen);
      1: begin
        push_char("3");
        push_char(iesc_pkg::ChLParen);
      end
      default: begin
        push_char("3");
        repeat (iesc_pkg::MaxNest) push_char(iesc_pkg::ChRParen);
      end
    endcase
    push_end();
  endfunction

  function automatic void add_expr();
    logic [7:0]  ops [4]   = '{iesc_pkg::ChPlus, iesc_pkg::ChMinus,
                               iesc_pkg::ChStar, iesc_pkg::ChSlash};
    logic [7:0]  sharp [6] = '{iesc_pkg::ChLParen, iesc_pkg::ChRParen, iesc_pkg::ChMinus,
                               iesc_pkg::ChLBrace, iesc_pkg::ChRBrace, "7"};
    logic [7:0]  body [$];
    logic [7:0]  c;
    int unsigned terms;
    int unsigned depth;
    int unsigned n;
    terms = $urandom_range(1, 5);
    depth = 0;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int t = 0; t < terms; t++) begin
        if (t != 0) body.push_back(ops[$urandom_range(0, 3)]);
        n = $urandom_range(0, 2);
        repeat (n) body.push_back(iesc_pkg::ChLParen);
        depth += n;
        if ($urandom_range(0, 3) == 0) begin
          body.push_back(iesc_pkg::ChLBrace);
          repeat ($urandom_range(0, 3)) begin
            c = 8'($urandom_range(0, 255));
            body.push_back((c == iesc_pkg::ChRBrace) ? iesc_pkg::ChLBrace : c);
          end
          body.push_back(iesc_pkg::ChRBrace);
        end else begin
          repeat ($urandom_range(1, 3))
            body.push_back(iesc_pkg::ChZero + 8'($urandom_range(0, 9)));
        end
        n = $urandom_range(0, depth);
        repeat (n) body.push_back(iesc_pkg::ChRParen);
        depth -= n;
      end
      repeat (depth) body.push_back(iesc_pkg::ChRParen);
      // corrupt some well-formed expressions
      case ($urandom_range(0, 9))
        6, 7: body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
        8: body.insert($urandom_range(0, body.size()), sharp[$urandom_range(0, 5)]);
        9: begin
          n = $urandom_range(0, body.size());
          while (body.size() > n) void'(body.pop_back());
        end
        default: ;
      endcase
    end
    foreach (body[i]) push_char(body[i]);
    push_end();
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin : sink_ready
    int unsigned run_len;
    int unsigned stall_len;
    forever begin
      run_len = $urandom_range(1, 24);
      if ($urandom_range(0, 9) == 0) run_len = 200;
      stall_len = pick_gap();
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (run_len - 1) @(negedge clk_i);
      if (stall_len != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: tdata=%02h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[1:0] != want.v) begin
          $error("verdict: expected %0d, got %0d", want.v, m_axis_tdata[1:0]);
          err_cnt++;
        end
        if (m_axis_tdata[5:2] != want.e) begin
          $error("error_code: expected %0d, got %0d", want.e, m_axis_tdata[5:2]);
          err_cnt++;
        end
        if (m_axis_tdata[7:6] != 2'b00) begin
          $error("pad: expected 0, got %0d", m_axis_tdata[7:6]);
          err_cnt++;
        end
        codes_seen[m_axis_tdata[5:2]] = 1'b1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t          row;
    iesc_pkg::verdict_e pv;
    iesc_pkg::err_e     pe;
    int unsigned        gap;
    int unsigned        burst_left;
    int unsigned        rand_items;
    int unsigned        expr_cnt;
    int unsigned        deep_kind;
    int unsigned        base;
    int unsigned        drain;

    foreach (DirTable[i]) begin
      stim_q.push_back(DirTable[i]);
      if (DirTable[i].op == iesc_pkg::OpEnd) expr_total++;
    end
    rand_items = 0;
    expr_cnt   = 0;
    deep_kind  = 0;
    while (rand_items < 300 || deep_kind < 3) begin
      base = stim_q.size();
      if (expr_cnt % 5 == 4 && deep_kind < 3) begin
        add_deep(deep_kind);
        deep_kind++;
      end else begin
        add_expr();
        rand_items += stim_q.size() - base;
      end
      expr_cnt++;
    end

    syntax_clear();
    burst_left = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_q[i]) begin
      row = stim_q[i];
      if (burst_left != 0) begin
        burst_left--;
        gap = 0;
      end else begin
        if ($urandom_range(0, 199) == 0) burst_left = 80;
        gap = pick_gap();
      end
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= row.ch;
      s_axis_tuser  <= row.op;
      do @(posedge clk_i); while (!s_axis_tready);
      syntax_step(row.op, row.ch, pv, pe);
      if (row.typed) pending_q.push_back(verdict_t'{row.v, row.e});
      else pending_q.push_back(verdict_t'{pv, pe});
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (pending_q.size() != 0 && drain < 20000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      err_cnt++;
    end

    $display("Sent %0d beats in %0d expressions, incl. nesting at the bound; %0d results checked.",
             stim_q.size(), expr_total, results_seen);
    $display("Error codes seen on the output (bit per code): %b", codes_seen);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/iesc_pkg.sv
design/iesc_front.sv
design/iesc_fifo.sv
design/iesc_back.sv
design/infix_expression_syntax_checker_core.sv
tb/infix_expression_syntax_checker_core_tb.sv
